### rtl/csvfs_pkg.sv
// Package for the CSV field splitter: payload structs, the parse phase enum
// and the character constants. There are no dependencies.
`timescale 1ns / 1ps

package csvfs_pkg;

  // Characters with a meaning to the parser
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;

  // Input request: one record byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_record;
  } csvfs_in_t;

  // Output request: a field byte or a field-end mark
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic       last_of_input;
  } csvfs_out_t;

  // Queue entry: the results of one input byte.
  // first_vld: a data byte or plain field-end mark comes first.
  // rec_mark:  a record-end mark follows (always the final result).
  typedef struct packed {
    logic       first_vld;
    logic [7:0] first_byte;
    logic       first_is_byte;
    logic       rec_mark;
  } csvfs_entry_t;

  // Parse phase
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PLAIN  = 2'd1,
    PH_QUOTED = 2'd2,
    PH_QSEEN  = 2'd3
  } csvfs_phase_e;

endpackage

### rtl/csvfs_front.sv
// Front end of the CSV field splitter: holds the parse phase and classifies
// each accepted byte into a queue entry. Depends on csvfs_pkg.
`timescale 1ns / 1ps

module csvfs_front import csvfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  csvfs_in_t    in_data_i,
  output csvfs_entry_t entry_o,
  output logic         has_result_o
);

  csvfs_phase_e phase_q, phase_d;
  logic [7:0]   c;
  logic         blank;

  assign c     = in_data_i.in_byte;
  assign blank = (c == ChSpace) || (c == ChTab);

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

  // Next phase and the results of this byte
  always_comb begin
    phase_d               = phase_q;
    entry_o.first_vld     = 1'b0;
    entry_o.first_byte    = 8'h00;
    entry_o.first_is_byte = 1'b0;
    entry_o.rec_mark      = 1'b0;
    unique case (phase_q)
      PH_PLAIN: begin
        entry_o.first_vld = 1'b1;
        if (c == ChComma) begin
          phase_d = PH_START;
        end else begin
          entry_o.first_byte    = c;
          entry_o.first_is_byte = 1'b1;
        end
      end
      PH_QUOTED: begin
        if (c == ChQuote) begin
          phase_d = PH_QSEEN;
        end else begin
          entry_o.first_vld     = 1'b1;
          entry_o.first_byte    = c;
          entry_o.first_is_byte = 1'b1;
        end
      end
      PH_QSEEN: begin
        entry_o.first_vld = 1'b1;
        if (c == ChQuote) begin
          // doubled quote gives one quote byte
          entry_o.first_byte    = ChQuote;
          entry_o.first_is_byte = 1'b1;
          phase_d               = PH_QUOTED;
        end else begin
          // closing quote confirmed, this byte is dropped
          phase_d = PH_START;
        end
      end
      PH_START: begin
        if (blank) begin
          // leading blank skipped
        end else if (c == ChQuote) begin
          phase_d = PH_QUOTED;
        end else if (c == ChComma) begin
          entry_o.first_vld = 1'b1;
        end else begin
          entry_o.first_vld     = 1'b1;
          entry_o.first_byte    = c;
          entry_o.first_is_byte = 1'b1;
          phase_d               = PH_PLAIN;
        end
      end
    endcase
    // implicit comma at record end
    if (in_data_i.end_of_record) begin
      entry_o.rec_mark = 1'b1;
      phase_d          = PH_START;
    end
  end

  assign has_result_o = entry_o.first_vld || entry_o.rec_mark;

endmodule

### rtl/csvfs_queue.sv
// Small FIFO of parse entries between front and back end.
// Depends on csvfs_pkg.
`timescale 1ns / 1ps

module csvfs_queue import csvfs_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  csvfs_entry_t wr_entry_i,
  input  logic         pop_i,
  output csvfs_entry_t rd_entry_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  csvfs_entry_t        mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_entry_o = mem_q[rptr_q];

  // Pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wr_entry_i;
    end
  end

endmodule

### rtl/csvfs_back.sv
// Back end of the CSV field splitter: expands queue entries into one or two
// output requests through an output register. Depends on csvfs_pkg.
`timescale 1ns / 1ps

module csvfs_back import csvfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  csvfs_entry_t entry_i,
  input  logic         empty_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output csvfs_out_t   out_data_o
);

  logic       sub_q, sub_d;
  logic       out_valid_q, out_valid_d;
  csvfs_out_t out_q, res;
  logic       load, step, done;

  // Output register may take a new request
  assign load = !out_valid_q || out_ready_i;
  assign step = load && !empty_i;

  // Pick the next result of the head entry
  always_comb begin
    if (!sub_q && entry_i.first_vld) begin
      res.out_byte      = entry_i.first_byte;
      res.byte_valid    = entry_i.first_is_byte;
      res.field_end     = !entry_i.first_is_byte;
      res.record_end    = 1'b0;
      res.last_of_input = !entry_i.rec_mark;
      done              = !entry_i.rec_mark;
    end else begin
      res.out_byte      = 8'h00;
      res.byte_valid    = 1'b0;
      res.field_end     = 1'b1;
      res.record_end    = 1'b1;
      res.last_of_input = 1'b1;
      done              = 1'b1;
    end
  end

  assign pop_o       = step && done;
  assign sub_d       = step ? !done : sub_q;
  assign out_valid_d = step ? 1'b1 : (load ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/csv_field_splitter.sv
// Top level of the CSV field splitter: front classifier, entry queue and
// output back end. Depends on csvfs_pkg, csvfs_front, csvfs_queue, csvfs_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one record byte per
//   request, end_of_record set on the last byte of a record. Output channel
//   (out_valid_o/out_ready_i/out_data_o) gives field bytes and field-end
//   marks; a mark with record_end closes the record. last_of_input flags the
//   final request caused by one input byte.
//   Results pass through the entry queue and the output register. Throughput:
//   one input byte per cycle while the queue is not full; one output request
//   per cycle while the receiver is ready, so a last byte with both a field
//   result and the record-end mark uses the port twice. The queue of
//   QueueDepth entries absorbs that and lets the input run on while the output
//   stalls. Bytes that yield nothing (skipped blanks, quotes) never enter the
//   queue. Reset: the parse phase returns to field start and queue and output
//   register empty. When the receiver stalls, the output register holds and
//   the queue fills; in_ready_o drops only when the queue is full.
`timescale 1ns / 1ps

module csv_field_splitter import csvfs_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  csvfs_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output csvfs_out_t out_data_o
);

  csvfs_entry_t wr_entry, rd_entry;
  logic         accept, has_result, push, pop, empty, full;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && has_result;

  // Classifier
  csvfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .entry_o     (wr_entry),
    .has_result_o(has_result)
  );

  // Entry queue
  csvfs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_entry_i(wr_entry),
    .pop_i     (pop),
    .rd_entry_o(rd_entry),
    .empty_o   (empty),
    .full_o    (full)
  );

  // Result emitter
  csvfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (rd_entry),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Checks
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_byte_or_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_valid != out_data_o.field_end))
    else $error("result is neither a single byte nor a single mark");

  a_rec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.record_end) |->
      (out_data_o.field_end && out_data_o.last_of_input))
    else $error("record-end mark not final field-end result");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.field_end) |-> (out_data_o.out_byte == 8'h00))
    else $error("mark result carries a nonzero byte");

endmodule

### verif/csv_field_splitter_tb.sv
// Self-checking testbench for csv_field_splitter: a scoreboard class predicts
// field bytes and field-end marks for every accepted record byte.
// Depends on csvfs_pkg and the csv_field_splitter RTL.
`timescale 1ns / 1ps

module csv_field_splitter_tb;
  import csvfs_pkg::*;

  // Scoreboard: mirrors the parse phase and holds the fields still owed
  class field_scoreboard;
    csvfs_phase_e phase;
    csvfs_out_t   pending_fields[$];
    int unsigned  errors;

    function new();
      phase  = PH_START;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    function csvfs_out_t field_byte(logic [7:0] c);
      csvfs_out_t r;
      r            = '0;
      r.out_byte   = c;
      r.byte_valid = 1'b1;
      return r;
    endfunction

    function csvfs_out_t field_mark(logic rec);
      csvfs_out_t r;
      r            = '0;
      r.field_end  = 1'b1;
      r.record_end = rec;
      return r;
    endfunction

    // Predict the results of one accepted record byte; returns their count
    function int note_byte(csvfs_in_t req);
      csvfs_out_t res[2];
      int n;
      logic [7:0] c;
      n = 0;
      c = req.in_byte;
      case (phase)
        PH_PLAIN: begin
          if (c == ChComma) begin
            res[n] = field_mark(1'b0);
            n++;
            phase = PH_START;
          end else begin
            res[n] = field_byte(c);
            n++;
          end
        end
        PH_QUOTED: begin
          if (c == ChQuote) begin
            phase = PH_QSEEN;
          end else begin
            res[n] = field_byte(c);
            n++;
          end
        end
        PH_QSEEN: begin
          if (c == ChQuote) begin
            // doubled quote gives one quote byte
            res[n] = field_byte(ChQuote);
            n++;
            phase = PH_QUOTED;
          end else begin
            // closing quote confirmed, this byte is dropped
            res[n] = field_mark(1'b0);
            n++;
            phase = PH_START;
          end
        end
        default: begin
          if (c == ChQuote) begin
            phase = PH_QUOTED;
          end else if (c == ChComma) begin
            res[n] = field_mark(1'b0);
            n++;
          end else if (c != ChSpace && c != ChTab) begin
            res[n] = field_byte(c);
            n++;
            phase = PH_PLAIN;
          end
        end
      endcase
      // implicit comma at the end of the record
      if (req.end_of_record) begin
        res[n] = field_mark(1'b1);
        n++;
        phase = PH_START;
      end
      for (int i = 0; i < n; i++) begin
        if (i == n - 1) res[i].last_of_input = 1'b1;
        pending_fields.insert(pending_fields.size(), res[i]);
      end
      return n;
    endfunction

    // Compare one accepted result with the oldest prediction
    task check_field(csvfs_out_t got);
      csvfs_out_t want;
      if (pending_fields.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h flags %b%b%b%b",
                                  got.out_byte, got.byte_valid, got.field_end,
                                  got.record_end, got.last_of_input));
      end else begin
        want = pending_fields.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid,
                                    want.byte_valid));
        if (got.field_end !== want.field_end)
          report_mismatch($sformatf("field_end %b, want %b", got.field_end, want.field_end));
        if (got.record_end !== want.record_end)
          report_mismatch($sformatf("record_end %b, want %b", got.record_end,
                                    want.record_end));
        if (got.last_of_input !== want.last_of_input)
          report_mismatch($sformatf("last_of_input %b, want %b", got.last_of_input,
                                    want.last_of_input));
      end
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  csvfs_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  csvfs_out_t out_data_o;

  field_scoreboard sb;
  int  send_idle_pct = 0;
  int  phase_idle    = 0;
  int  stall_pct     = 0;
  bit  hold_off      = 1'b0;
  int  sent_items    = 0;

  csv_field_splitter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i = !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_field(out_data_o);
  end

  // Long receiver hold-off, counted in its own process
  task automatic hold_output(int cycles);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  // Offer one record byte and wait for its acceptance; called at a falling edge
  task automatic send_byte(logic [7:0] b, logic eor);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i               = 1'b1;
    in_data_i.in_byte        = b;
    in_data_i.end_of_record  = eor;
    do @(posedge clk_i); while (!in_ready_o);
    void'(sb.note_byte(in_data_i));
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Stop offering until every predicted result has come out
  task automatic drain_fields();
    in_valid_i = 1'b0;
    while (sb.pending_fields.size() != 0) @(negedge clk_i);
  endtask

  // Record with random content: plain, quoted and empty fields
  task automatic send_record();
    logic [7:0] text[$];
    int fields;
    int kind;
    int len;
    bit sep_done;
    logic [7:0] c;
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      sep_done = 1'b0;
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2))
          text.insert(text.size(), $urandom_range(1) ? ChSpace : ChTab);
      end
      kind = $urandom_range(9);
      len  = $urandom_range(0, 6);
      if (kind < 5) begin
        // plain field: anything but a comma; quotes are data unless first
        for (int i = 0; i < len; i++) begin
          c = 8'($urandom_range(255));
          text.insert(text.size(), c == ChComma ? 8'h5F : c);
        end
      end else if (kind < 9) begin
        text.insert(text.size(), ChQuote);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(5))
            0: begin
              text.insert(text.size(), ChQuote);
              text.insert(text.size(), ChQuote);
            end
            1: text.insert(text.size(), ChComma);
            default: begin
              c = 8'($urandom_range(255));
              text.insert(text.size(), c == ChQuote ? 8'h27 : c);
            end
          endcase
        end
        if (f < fields - 1) begin
          // closing quote, then the dropped byte acts as separator
          text.insert(text.size(), ChQuote);
          text.insert(text.size(),
                      $urandom_range(7) == 0 ? 8'($urandom_range(255)) : ChComma);
          sep_done = 1'b1;
        end else if ($urandom_range(4) != 0) begin
          text.insert(text.size(), ChQuote);
          if ($urandom_range(1)) text.insert(text.size(), 8'($urandom_range(255)));
        end
      end
      if (f < fields - 1 && !sep_done) text.insert(text.size(), ChComma);
    end
    if ($urandom_range(5) == 0 || text.size() == 0) text.insert(text.size(), ChComma);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  // Noise: bytes biased toward the special characters, random record ends
  task automatic send_noise();
    int len;
    logic [7:0] c;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(4))
        0: c = ChQuote;
        1: c = ChComma;
        2: c = $urandom_range(1) ? ChSpace : ChTab;
        default: c = 8'($urandom_range(255));
      endcase
      send_byte(c, (i == len - 1) || ($urandom_range(5) == 0));
    end
  endtask

  // Stimulus
  initial begin
    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty fields, blanks, quoted forms, record-end corners
    send_text(",");
    send_text(" \ta\" ,");
    send_text("\"x,\"\"\"z");
    send_text("\"q\"");
    send_text("\"u\"\"");
    send_text("\"o");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_fields();

    // random phases with different idling
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          phase_idle = 0;
          stall_pct  = 0;
        end
        1: begin
          phase_idle = 76;
          stall_pct  = 0;
        end
        2: begin
          phase_idle = 0;
          stall_pct  = 76;
        end
        default: begin
          phase_idle = 15;
          stall_pct  = 15;
        end
      endcase
      if (p == 0) begin
        fork
          hold_output(300);
        join_none
      end
      while (sent_items < (p + 1) * 490) begin
        send_idle_pct = phase_idle;
        if ($urandom_range(7) == 0) send_noise();
        else send_record();
      end
      drain_fields();
    end

    repeat (16) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
